// ===== rtl/lmc3_pkg.sv =====
`timescale 1ns / 1ps

package lmc3_pkg;

  // Default build sizes
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int PIXEL_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 21;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Register map, selected by paddr[2]
  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_t;

  // Neighbour offsets around a centre: row step and column step
  localparam int NUM_NB = 8;
  localparam int NB_DR [NUM_NB] = '{-1, -1, -1,  0, 0,  1, 1, 1};
  localparam int NB_DC [NUM_NB] = '{-1,  0,  1, -1, 1, -1, 0, 1};

  // Position flags carried down the pipeline with each word
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

// ===== rtl/local_maximum_counter_3x3_core.sv =====
`timescale 1ns / 1ps

// The count word is registered for out_valid once the last pixel has left stage 2.
// One pixel per cycle unless the count word is held; one line read and write per cycle.
// Pipeline: input counters and line read, window shift and line write, compare and count.
// Reset clears positions, the running count, the window and the word valid flags; both size
// registers return to 1. The line memory is not cleared and needs no clearing pass.
module local_maximum_counter_3x3_core
  import lmc3_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [PIXEL_WIDTH-1:0] in_pixel_value,
  // count output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [COUNT_W-1:0]     out_maxima_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic        [APB_AW-1:0]      paddr,
  input  logic        [APB_DW-1:0]      pwdata,
  output logic        [APB_DW-1:0]      prdata,
  output logic                          pready
);

  localparam int PW     = PIXEL_WIDTH;
  localparam int CW     = $clog2(MAX_COLUMNS);
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCMP_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RCMP_W = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int MCMP_W = 15;

  typedef logic signed [PW-1:0] win_t [3][3];

  typedef struct packed {
    logic signed [PW-1:0] older;
    logic signed [PW-1:0] newer;
  } line_word_t;

  // Decide whether window cell (cr, cc) beats all eight neighbours
  function automatic logic judge(input win_t w, input int cr, input int cc,
                                 input logic top_ok, input logic left_ok);
    logic                 res;
    int                   i;
    int                   j;
    logic signed [PW-1:0] v;
    res = 1'b1;
    for (int k = 0; k < NUM_NB; k++) begin
      i = cr + NB_DR[k];
      j = cc + NB_DC[k];
      if (i > 2 || j > 2 || (NB_DR[k] < 0 && !top_ok) || (NB_DC[k] < 0 && !left_ok)) begin
        v = '0;
      end else begin
        v = w[i][j];
      end
      if (w[cr][cc] <= v) begin
        res = 1'b0;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] row_cnt_r;
  logic [CFG_W-1:0] col_cnt_r;
  logic             cfg_wr;
  logic [CFG_W-1:0] cfg_raw;
  logic [CFG_W-1:0] row_clamp;
  logic [CFG_W-1:0] col_clamp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_raw = pwdata[CFG_W-1:0];

  // Clamp: zero reads as one, anything above the maximum as the maximum
  always_comb begin
    if (cfg_raw == '0) begin
      row_clamp = CFG_W'(1);
      col_clamp = CFG_W'(1);
    end else begin
      row_clamp = (MCMP_W'(cfg_raw) > MCMP_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg_raw;
      col_clamp = (MCMP_W'(cfg_raw) > MCMP_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cfg_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= CFG_W'(1);
      col_cnt_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_ROW_COUNT:    row_cnt_r <= row_clamp;
        REG_COLUMN_COUNT: col_cnt_r <= col_clamp;
        default:          row_cnt_r <= row_cnt_r;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_ROW_COUNT:    prdata = APB_DW'(row_cnt_r);
      REG_COLUMN_COUNT: prdata = APB_DW'(col_cnt_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: everything advances unless a count word is held
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_fire;
  logic out_valid_r;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign in_fire  = in_valid && advance;

  // ---------------------------------------------------------------------------
  // Input stage: position counters and line memory read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_pos_r;
  logic [RW-1:0] row_pos_r;
  pos_flags_t    flags_in;

  always_comb begin
    flags_in.r_ge1    = (row_pos_r != '0);
    flags_in.r_ge2    = (row_pos_r > RW'(1));
    flags_in.c_ge1    = (col_pos_r != '0);
    flags_in.c_ge2    = (col_pos_r > CW'(1));
    flags_in.last_col = (CCMP_W'(col_pos_r) + CCMP_W'(1) >= CCMP_W'(col_cnt_r));
    flags_in.last_row = (RCMP_W'(row_pos_r) + RCMP_W'(1) >= RCMP_W'(row_cnt_r));
  end

  // Advance the raster position; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cfg_wr) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_fire) begin
      if (flags_in.last_col) begin
        col_pos_r <= '0;
        row_pos_r <= flags_in.last_row ? '0 : row_pos_r + RW'(1);
      end else begin
        col_pos_r <= col_pos_r + CW'(1);
      end
    end
  end

  // Stage 1 registers
  logic                 s1_v_r;
  logic signed [PW-1:0] s1_pix_r;
  logic [CW-1:0]        s1_addr_r;
  pos_flags_t           s1_flags_r;
  line_word_t           rd_r;
  line_word_t           wr_word;
  logic                 mem_wr;

  line_word_t line_mem [MAX_COLUMNS];

  // Push the column down: the newer row becomes the older one
  assign wr_word.older = rd_r.newer;
  assign wr_word.newer = s1_pix_r;
  assign mem_wr        = advance && s1_v_r;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_mem[s1_addr_r] <= wr_word;
    end
    // Forward a write to the same column landing at this edge
    if (in_fire) begin
      if (mem_wr && s1_addr_r == col_pos_r) begin
        rd_r <= wr_word;
      end else begin
        rd_r <= line_mem[col_pos_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_pixel_value;
      s1_addr_r  <= col_pos_r;
      s1_flags_r <= flags_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: 3x3 window
  // ---------------------------------------------------------------------------
  logic       s2_v_r;
  pos_flags_t s2_flags_r;
  win_t       win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (advance) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        // Shift left and load the new column
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= rd_r.older;
        win_r[1][2] <= rd_r.newer;
        win_r[2][2] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      s2_flags_r <= s1_flags_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare and count
  // ---------------------------------------------------------------------------
  logic               hit_mid;
  logic               hit_right;
  logic               hit_low;
  logic               hit_corner;
  logic               s2_final;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] out_count_r;

  assign hit_mid    = s2_flags_r.r_ge1 && s2_flags_r.c_ge1 &&
                      judge(win_r, 1, 1, s2_flags_r.r_ge2, s2_flags_r.c_ge2);
  assign hit_right  = s2_flags_r.r_ge1 && s2_flags_r.last_col &&
                      judge(win_r, 1, 2, s2_flags_r.r_ge2, s2_flags_r.c_ge1);
  assign hit_low    = s2_flags_r.last_row && s2_flags_r.c_ge1 &&
                      judge(win_r, 2, 1, s2_flags_r.r_ge1, s2_flags_r.c_ge2);
  assign hit_corner = s2_flags_r.last_row && s2_flags_r.last_col &&
                      judge(win_r, 2, 2, s2_flags_r.r_ge1, s2_flags_r.c_ge1);
  assign s2_final   = s2_flags_r.last_row && s2_flags_r.last_col;

  assign count_nxt = count_r + COUNT_W'(hit_mid) + COUNT_W'(hit_right)
                   + COUNT_W'(hit_low) + COUNT_W'(hit_corner);

  // Accumulate; drop the total into the output word on the last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        count_r <= '0;
      end else if (advance && s2_v_r) begin
        count_r <= s2_final ? '0 : count_nxt;
      end
      if (advance) begin
        out_valid_r <= s2_v_r && s2_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_v_r && s2_final) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_maxima_count = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r && s2_final))
    else $error("count word raised without a final pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CCMP_W'(col_pos_r) < CCMP_W'(col_cnt_r))
    else $error("column position past column count");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    RCMP_W'(row_pos_r) < RCMP_W'(row_cnt_r))
    else $error("row position past row count");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !cfg_wr) |=> $stable(count_r) && $stable(out_count_r))
    else $error("count changed while output held");

endmodule

// ===== sim/local_maximum_counter_3x3_core_tb.sv =====
`timescale 1ns / 1ps

module local_maximum_counter_3x3_core_tb;
  import lmc3_pkg::*;

  localparam int LIMIT_CYCLES = 500000;

  typedef logic signed [PIXEL_WIDTH_DEF-1:0] pixel_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum int {PIX_FULL, PIX_NARROW, PIX_PEAKS, PIX_NEGATIVE} pixel_mode_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD, STALL_TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_t in_pixel_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  count_t out_maxima_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // Shadow of the block: line stores, 3x3 neighbourhood, positions, sizes
  pixel_t older_line [MAX_COLUMNS_DEF];
  pixel_t newer_line [MAX_COLUMNS_DEF];
  pixel_t nbhd [3][3];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  int unsigned rows_cfg = 1;
  int unsigned cols_cfg = 1;
  count_t peak_total = '0;
  count_t expected_counts [$];

  // Run bookkeeping
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned writes_done = 0;
  int unsigned reads_done = 0;
  int unsigned counts_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;
  count_t want;

  always #10 clk = ~clk;

  local_maximum_counter_3x3_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_maxima_count (out_maxima_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (nbhd[i, j]) nbhd[i][j] = '0;
  end

  // A centre counts only if strictly above all eight neighbours; outside cells read as zero
  function automatic bit is_strict_peak(int cr, int cc, bit top_ok, bit left_ok);
    pixel_t centre;
    pixel_t other;
    int i;
    int j;
    centre = nbhd[cr][cc];
    for (int k = 0; k < NUM_NB; k++) begin
      i = cr + NB_DR[k];
      j = cc + NB_DC[k];
      if (i > 2 || j > 2 || (NB_DR[k] < 0 && !top_ok) || (NB_DC[k] < 0 && !left_ok))
        other = '0;
      else
        other = nbhd[i][j];
      if (centre <= other) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow by one accepted pixel; queue the total on the last pixel of a frame
  function automatic void track_pixel(pixel_t pix);
    int unsigned ci;
    bit last_c;
    bit last_r;
    ci = col_pos % MAX_COLUMNS_DEF;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = older_line[ci];
    nbhd[1][2] = newer_line[ci];
    nbhd[2][2] = pix;
    older_line[ci] = newer_line[ci];
    newer_line[ci] = pix;
    last_c = (col_pos + 1 >= cols_cfg);
    last_r = (row_pos + 1 >= rows_cfg);

    // Decide every centre whose neighbours are now all known
    if (row_pos >= 1 && col_pos >= 1)
      peak_total += is_strict_peak(1, 1, row_pos >= 2, col_pos >= 2);
    if (row_pos >= 1 && last_c)
      peak_total += is_strict_peak(1, 2, row_pos >= 2, col_pos >= 1);
    if (last_r && col_pos >= 1)
      peak_total += is_strict_peak(2, 1, row_pos >= 1, col_pos >= 2);
    if (last_r && last_c)
      peak_total += is_strict_peak(2, 2, row_pos >= 1, col_pos >= 1);

    if (last_c) begin
      col_pos = 0;
      if (last_r) begin
        expected_counts.push_back(peak_total);
        row_pos = 0;
        peak_total = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // Size registers take the low 11 bits; zero reads as one, above the top reads as the top
  function automatic int unsigned size_from_reg(logic [APB_DW-1:0] value, int unsigned top);
    int unsigned v;
    v = value[CFG_W-1:0];
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Encode a size, sometimes with junk above the field or as zero for one
  function automatic logic [APB_DW-1:0] encode_size(int unsigned n);
    logic [APB_DW-1:0] v;
    v = ($urandom_range(1, 0) != 0) ? APB_DW'($urandom) : '0;
    v[CFG_W-1:0] = (n == 1 && $urandom_range(1, 0) != 0) ? '0 : CFG_W'(n);
    return v;
  endfunction

  function automatic pixel_t random_pixel(pixel_mode_t mode);
    case (mode)
      PIX_NARROW:   return pixel_t'(int'($urandom_range(6, 0)) - 3);
      PIX_PEAKS: begin
        if ($urandom_range(4, 0) == 0) return pixel_t'($urandom_range(32767, 1000));
        return pixel_t'(int'($urandom_range(40, 0)) - 20);
      end
      PIX_NEGATIVE: return pixel_t'(-int'($urandom_range(32768, 1)));
      default:      return pixel_t'($urandom);
    endcase
  endfunction

  // Drive one pixel word, with a random gap between bursts, and hold it until taken
  task automatic send_pixel(pixel_t pix);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(7, 0) == 0) ? $urandom_range(15, 6) : $urandom_range(4, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(24, 1);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_pixel(pix);
    pixels_sent++;
  endtask

  // Drop valid and hold until every count word is back, then let the pipeline empty
  task automatic wait_for_counts;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    wait_for_counts;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    // Any write restarts the frame; the line stores keep their contents
    if (idx == REG_ROW_COUNT)
      rows_cfg = size_from_reg(value, MAX_ROWS_DEF);
    else
      cols_cfg = size_from_reg(value, MAX_COLUMNS_DEF);
    row_pos = 0;
    col_pos = 0;
    peak_total = '0;
    writes_done++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Read a size register back over the configuration port
  task automatic check_size_reg(reg_idx_t idx, int unsigned exp_size);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    reads_done++;
    if (prdata !== APB_DW'(exp_size)) begin
      $display("%0t: size register %0d read back wrong: expected %0d, actual %0d",
               $time, idx, exp_size, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame_size(logic [APB_DW-1:0] rows, logic [APB_DW-1:0] cols);
    if ($urandom_range(1, 0) != 0) begin
      write_size_reg(REG_ROW_COUNT, rows);
      write_size_reg(REG_COLUMN_COUNT, cols);
    end else begin
      write_size_reg(REG_COLUMN_COUNT, cols);
      write_size_reg(REG_ROW_COUNT, rows);
    end
  endtask

  task automatic send_frame(pixel_mode_t mode);
    repeat (rows_cfg * cols_cfg) send_pixel(random_pixel(mode));
    frames_sent++;
  endtask

  // Sizes straight out of reset are 1x1: every pixel is a frame of its own
  task automatic test_reset_size;
    pixel_t pat [$];
    gaps_on = 1'b0;
    pat = {16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    foreach (pat[i]) send_pixel(pat[i]);
    frames_sent += pat.size();
  endtask

  // One row and one column: the missing neighbours read as zero
  task automatic test_single_line;
    pixel_t pat [$];
    gaps_on = 1'b1;
    set_frame_size(1, 5);
    pat = {16'sd3, 16'sd7, 16'sd2, 16'sd9, -16'sd1};
    foreach (pat[i]) send_pixel(pat[i]);
    set_frame_size(3, 1);
    pat = {-16'sd5, 16'sd4, -16'sd7};
    foreach (pat[i]) send_pixel(pat[i]);
    frames_sent += 2;
  endtask

  // Centre peak in a 3x3 and a 2x2 of the field extremes
  task automatic test_small_patterns;
    pixel_t pat [$];
    set_frame_size(3, 3);
    pat = {16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd100, 16'sd5, 16'sd5, 16'sd5, 16'sd5};
    foreach (pat[i]) send_pixel(pat[i]);
    set_frame_size(2, 2);
    pat = {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
    foreach (pat[i]) send_pixel(pat[i]);
    frames_sent += 2;
  endtask

  // Abandon a frame part way, restart it by a register write, then run it whole
  task automatic test_restart_mid_frame;
    set_frame_size(3, 4);
    repeat (5) send_pixel(random_pixel(PIX_FULL));
    write_size_reg(REG_COLUMN_COUNT, 4);
    send_frame(PIX_NARROW);
  endtask

  // Register extremes: zero, the top, above the top and junk above the field
  task automatic test_size_limits;
    gaps_on = 1'b1;
    set_frame_size(2047, 0);
    check_size_reg(REG_ROW_COUNT, MAX_ROWS_DEF);
    check_size_reg(REG_COLUMN_COUNT, 1);
    set_frame_size(1024, 2047);
    check_size_reg(REG_ROW_COUNT, MAX_ROWS_DEF);
    check_size_reg(REG_COLUMN_COUNT, MAX_COLUMNS_DEF);
    set_frame_size(32'h0000_0800, 32'hFFFF_F807);
    check_size_reg(REG_ROW_COUNT, 1);
    check_size_reg(REG_COLUMN_COUNT, 7);
    send_frame(PIX_PEAKS);
    gaps_on = 1'b0;
    set_frame_size(32'hFFFF_F803, 32'h0000_0804);
    check_size_reg(REG_ROW_COUNT, 3);
    check_size_reg(REG_COLUMN_COUNT, 4);
    send_frame(PIX_NARROW);
  endtask

  // Mostly whole frames of small random size and content, with some broken ones
  task automatic test_random_frames;
    int unsigned top;
    int unsigned cut;
    bit first;
    pixel_mode_t mode;
    first = 1'b1;
    while (pixels_sent < 500) begin
      if (first || $urandom_range(2, 0) != 0) begin
        first = 1'b0;
        top = ($urandom_range(19, 0) == 0) ? 16 : (($urandom_range(3, 0) == 0) ? 9 : 6);
        set_frame_size(encode_size($urandom_range(top, 1)), encode_size($urandom_range(top, 1)));
      end else if ($urandom_range(3, 0) == 0) begin
        wait_for_counts;
      end
      mode = pixel_mode_t'($urandom_range(3, 0));
      gaps_on = ($urandom_range(4, 0) != 0);
      if (rows_cfg * cols_cfg > 1 && $urandom_range(9, 0) == 0) begin
        cut = $urandom_range(rows_cfg * cols_cfg - 1, 1);
        repeat (cut) send_pixel(random_pixel(mode));
        write_size_reg(REG_COLUMN_COUNT, cols_cfg);
      end
      send_frame(mode);
    end
  endtask

  // Receiver stall pattern, independent of the sender
  initial begin : out_stall_pattern
    stall_mode_t mode;
    int unsigned span;
    forever begin
      mode = stall_mode_t'($urandom_range(3, 0));
      span = $urandom_range(60, 10);
      case (mode)
        STALL_NONE: begin
          repeat (span) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end
        STALL_RANDOM: begin
          repeat (span) begin
            @(negedge clk);
            out_stall <= ($urandom_range(2, 0) == 0);
          end
        end
        STALL_HOLD: begin
          repeat (span / 3) begin
            @(negedge clk);
            out_stall <= 1'b1;
          end
        end
        default: begin
          repeat (span) begin
            @(negedge clk);
            out_stall <= ~out_stall;
          end
        end
      endcase
    end
  end

  // Compare each accepted count word with the oldest expected total
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: count word with none due: expected none, actual %0d",
                 $time, out_maxima_count);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        counts_checked++;
        if (out_maxima_count !== want) begin
          $display("%0t: maxima count wrong: expected %0d, actual %0d",
                   $time, want, out_maxima_count);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("local_maximum_counter_3x3_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size;
    test_single_line;
    test_small_patterns;
    test_restart_mid_frame;
    test_size_limits;
    test_random_frames;

    wait_for_counts;
    repeat (8) @(posedge clk);
    $display("Run covered %0d pixels over %0d frames, %0d size writes and %0d read-backs.",
             pixels_sent, frames_sent, writes_done, reads_done);
    $display("%0d count words checked, %0d faults found.", counts_checked, errors);
    if (errors == 0) begin
      $display("local_maximum_counter_3x3_core: match");
    end else begin
      $display("local_maximum_counter_3x3_core: mismatch");
    end
    $finish;
  end

endmodule
